// ===== hdl/aes_pcbc_pkg.sv =====
package aes_pcbc_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXP_INIT,
    ST_EXPAND,
    ST_START,
    ST_INIT,
    ST_ROUND,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    REG_KEY_WORD_0 = 3'd0,
    REG_KEY_WORD_1 = 3'd1,
    REG_KEY_WORD_2 = 3'd2,
    REG_KEY_WORD_3 = 3'd3,
    REG_KEY_LENGTH = 3'd4,
    REG_DIRECTION  = 3'd5,
    REG_IV_HIGH    = 3'd6,
    REG_IV_LOW     = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KL_128 = 2'd0,
    KL_192 = 2'd1,
    KL_256 = 2'd2,
    KL_RSV = 2'd3
  } key_len_t;

  localparam logic DIR_DECRYPT = 1'b1;

  localparam int KEY_BYTES_128 = 16;
  localparam int KEY_BYTES_192 = 24;
  localparam int KEY_BYTES_256 = 32;
  localparam int ROUNDS_128 = 10;
  localparam int ROUNDS_192 = 12;
  localparam int ROUNDS_256 = 14;
  localparam int SCHED_BYTES_128 = 176;
  localparam int SCHED_BYTES_192 = 208;
  localparam int SCHED_BYTES_256 = 240;

  localparam logic [7:0] RCON_INIT = 8'h01;
  localparam logic [7:0] GF_POLY   = 8'h1b;
  localparam logic [7:0] GF_MSB    = 8'h80;

  typedef struct packed {
    logic take;
    logic exp_init;
    logic exp_step;
    logic blk_start;
    logic blk_init;
    logic blk_round;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic exp_last;
    logic round_last;
    logic out_busy;
    logic key_wr;
  } dp_stat_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (((a & GF_MSB) != 8'h00) ? GF_POLY : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [127:0] sub_fwd(input logic [127:0] s);
    logic [127:0] t;
    for (int i = 0; i < 16; i++) t[127-8*i -: 8] = SBOX[s[127-8*i -: 8]];
    sub_fwd = t;
  endfunction

  function automatic logic [127:0] sub_inv(input logic [127:0] s);
    logic [127:0] t;
    for (int i = 0; i < 16; i++) t[127-8*i -: 8] = INV_SBOX[s[127-8*i -: 8]];
    sub_inv = t;
  endfunction

  function automatic logic [127:0] shift_fwd(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127-8*(4*c+r) -: 8] = s[127-8*(4*((c+r)%4)+r) -: 8];
    shift_fwd = t;
  endfunction

  function automatic logic [127:0] shift_inv(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127-8*(4*c+r) -: 8] = s[127-8*(4*((c+4-r)%4)+r) -: 8];
    shift_inv = t;
  endfunction

  function automatic logic [127:0] mix_fwd(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      t[127-32*c -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      t[119-32*c -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      t[111-32*c -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      t[103-32*c -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
    mix_fwd = t;
  endfunction

  function automatic logic [7:0] m9(input logic [7:0] a);
    m9 = xt(xt(xt(a))) ^ a;
  endfunction

  function automatic logic [7:0] m11(input logic [7:0] a);
    m11 = xt(xt(xt(a))) ^ xt(a) ^ a;
  endfunction

  function automatic logic [7:0] m13(input logic [7:0] a);
    m13 = xt(xt(xt(a))) ^ xt(xt(a)) ^ a;
  endfunction

  function automatic logic [7:0] m14(input logic [7:0] a);
    m14 = xt(xt(xt(a))) ^ xt(xt(a)) ^ xt(a);
  endfunction

  function automatic logic [127:0] mix_inv(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127-32*c -: 8];
      a1 = s[119-32*c -: 8];
      a2 = s[111-32*c -: 8];
      a3 = s[103-32*c -: 8];
      t[127-32*c -: 8] = m14(a0) ^ m11(a1) ^ m13(a2) ^ m9(a3);
      t[119-32*c -: 8] = m9(a0) ^ m14(a1) ^ m11(a2) ^ m13(a3);
      t[111-32*c -: 8] = m13(a0) ^ m9(a1) ^ m14(a2) ^ m11(a3);
      t[103-32*c -: 8] = m11(a0) ^ m13(a1) ^ m9(a2) ^ m14(a3);
    end
    mix_inv = t;
  endfunction

  function automatic logic [3:0] lvl_nk(input logic [1:0] lvl);
    case (lvl)
      KL_128:  lvl_nk = 4'(KEY_BYTES_128 / 4);
      KL_192:  lvl_nk = 4'(KEY_BYTES_192 / 4);
      default: lvl_nk = 4'(KEY_BYTES_256 / 4);
    endcase
  endfunction

  function automatic logic [3:0] lvl_nr(input logic [1:0] lvl);
    case (lvl)
      KL_128:  lvl_nr = 4'(ROUNDS_128);
      KL_192:  lvl_nr = 4'(ROUNDS_192);
      default: lvl_nr = 4'(ROUNDS_256);
    endcase
  endfunction

endpackage

// ===== hdl/aes_pcbc_if.sv =====
interface aes_pcbc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_high;
  logic [63:0] block_low;
  modport source (output valid, output block_high, output block_low, input ready);
  modport sink (input valid, input block_high, input block_low, output ready);
endinterface

interface aes_pcbc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  modport source (output valid, output result_high, output result_low, input ready);
  modport sink (input valid, input result_high, input result_low, output ready);
endinterface

interface aes_pcbc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/aes_pcbc_ram.sv =====
module aes_pcbc_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/aes_pcbc_ctrl.sv =====
module aes_pcbc_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  aes_pcbc_pkg::dp_stat_t stat,
  output aes_pcbc_pkg::ctrl_cmd_t cmd
);

  aes_pcbc_pkg::state_t state_r, state_nxt;
  logic sched_ready_r, sched_ready_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= aes_pcbc_pkg::ST_IDLE;
      sched_ready_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      sched_ready_r <= sched_ready_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    sched_ready_nxt = sched_ready_r;
    cmd             = '0;
    in_ready        = 1'b0;
    if (stat.key_wr) begin
      sched_ready_nxt = 1'b0;
    end
    unique case (state_r)
      aes_pcbc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = sched_ready_r ? aes_pcbc_pkg::ST_START : aes_pcbc_pkg::ST_EXP_INIT;
        end
      end
      aes_pcbc_pkg::ST_EXP_INIT: begin
        cmd.exp_init = 1'b1;
        state_nxt    = aes_pcbc_pkg::ST_EXPAND;
      end
      aes_pcbc_pkg::ST_EXPAND: begin
        cmd.exp_step = 1'b1;
        if (stat.exp_last) begin
          sched_ready_nxt = 1'b1;
          state_nxt       = aes_pcbc_pkg::ST_START;
        end
      end
      aes_pcbc_pkg::ST_START: begin
        cmd.blk_start = 1'b1;
        state_nxt     = aes_pcbc_pkg::ST_INIT;
      end
      aes_pcbc_pkg::ST_INIT: begin
        cmd.blk_init = 1'b1;
        state_nxt    = aes_pcbc_pkg::ST_ROUND;
      end
      aes_pcbc_pkg::ST_ROUND: begin
        cmd.blk_round = 1'b1;
        if (stat.round_last) begin
          state_nxt = aes_pcbc_pkg::ST_DONE;
        end
      end
      aes_pcbc_pkg::ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = aes_pcbc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = aes_pcbc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/aes_pcbc_dp.sv =====
module aes_pcbc_dp #(
  parameter int EXPANDED_KEY_BYTES = 240
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  aes_pcbc_pkg::ctrl_cmd_t cmd,
  output aes_pcbc_pkg::dp_stat_t  stat,
  input  logic [127:0]            in_data,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_idx,
  input  logic [63:0]             cfg_data,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [127:0]            out_data
);

  localparam int WORDS = EXPANDED_KEY_BYTES / 4;
  localparam int ROWS  = EXPANDED_KEY_BYTES / 16;
  localparam int AW    = $clog2(ROWS);
  localparam int WIW   = $clog2(WORDS);

  logic [63:0]  key_r [4];
  logic [1:0]   klen_r;
  logic         dir_r;
  logic [63:0]  ivh_r, ivl_r;
  logic [127:0] chain_r, chain_nxt;
  logic [127:0] blk_r;
  logic [127:0] st_r, st_nxt;
  logic [127:0] res_r, res_nxt;
  logic         out_valid_r, out_valid_nxt;

  logic [31:0]    win_r [8];
  logic [31:0]    row_r [3];
  logic [WIW-1:0] wi_r;
  logic [2:0]     kc_r;
  logic [7:0]     rc_r;
  logic [1:0]     lvl_r, lvl_nxt;
  logic [AW-1:0]  rk_r, rk_nxt;
  logic [3:0]     rcnt_r;

  logic [3:0]    nk, nr;
  logic [31:0]   w_new, t_w, old_w;
  logic [63:0]   kw;
  logic          rk_we;
  logic [127:0]  rk_data;
  logic [127:0]  enc_t, dec_t;
  logic [127:0]  st_key;

  assign nk = aes_pcbc_pkg::lvl_nk(lvl_r);
  assign nr = aes_pcbc_pkg::lvl_nr(lvl_r);

  always_comb begin
    if (klen_r == aes_pcbc_pkg::KL_RSV) begin
      lvl_nxt = aes_pcbc_pkg::KL_256;
    end else begin
      lvl_nxt = klen_r;
    end
    if (lvl_nxt == aes_pcbc_pkg::KL_256 &&
        aes_pcbc_pkg::SCHED_BYTES_256 > EXPANDED_KEY_BYTES) begin
      lvl_nxt = aes_pcbc_pkg::KL_192;
    end
    if (lvl_nxt == aes_pcbc_pkg::KL_192 &&
        aes_pcbc_pkg::SCHED_BYTES_192 > EXPANDED_KEY_BYTES) begin
      lvl_nxt = aes_pcbc_pkg::KL_128;
    end
  end

  // key expansion, one word per cycle
  always_comb begin
    kw = key_r[wi_r[2:1]];
    case (lvl_r)
      aes_pcbc_pkg::KL_128: old_w = win_r[4];
      aes_pcbc_pkg::KL_192: old_w = win_r[2];
      default:              old_w = win_r[0];
    endcase
    t_w = win_r[7];
    if (kc_r == 3'd0) begin
      t_w = aes_pcbc_pkg::sub_word({win_r[7][23:0], win_r[7][31:24]}) ^ {rc_r, 24'h0};
    end else if (nk == 4'd8 && kc_r == 3'd4) begin
      t_w = aes_pcbc_pkg::sub_word(win_r[7]);
    end
    if (wi_r < WIW'(nk)) begin
      w_new = wi_r[0] ? kw[31:0] : kw[63:32];
    end else begin
      w_new = old_w ^ t_w;
    end
    rk_we   = cmd.exp_step && (wi_r[1:0] == 2'd3);
    rk_data = {row_r[0], row_r[1], row_r[2], w_new};
  end

  assign stat.exp_last = (wi_r == WIW'(4 * ({2'b00, nr} + 6'd1) - 1));

  always_ff @(posedge clk) begin
    if (cmd.exp_init) begin
      lvl_r <= lvl_nxt;
      wi_r  <= '0;
      kc_r  <= '0;
      rc_r  <= aes_pcbc_pkg::RCON_INIT;
    end else if (cmd.exp_step) begin
      for (int j = 0; j < 7; j++) win_r[j] <= win_r[j+1];
      win_r[7] <= w_new;
      if (wi_r[1:0] != 2'd3) begin
        row_r[wi_r[1:0]] <= w_new;
      end
      wi_r <= wi_r + 1'b1;
      kc_r <= ({1'b0, kc_r} == nk - 4'd1) ? 3'd0 : kc_r + 3'd1;
      if (kc_r == 3'd0 && wi_r >= WIW'(nk)) begin
        rc_r <= aes_pcbc_pkg::xt(rc_r);
      end
    end
  end

  aes_pcbc_ram #(
    .WIDTH(128),
    .DEPTH(ROWS)
  ) u_rk_ram (
    .clk  (clk),
    .we   (rk_we),
    .waddr(AW'(wi_r >> 2)),
    .wdata(rk_data),
    .raddr(rk_nxt),
    .rdata(st_key)
  );

  // round datapath
  always_comb begin
    rk_nxt = rk_r;
    st_nxt = st_r;
    enc_t  = aes_pcbc_pkg::shift_fwd(aes_pcbc_pkg::sub_fwd(st_r));
    if (rcnt_r != nr) begin
      enc_t = aes_pcbc_pkg::mix_fwd(enc_t);
    end
    enc_t = enc_t ^ st_key;
    dec_t = aes_pcbc_pkg::sub_inv(aes_pcbc_pkg::shift_inv(st_r)) ^ st_key;
    if (rcnt_r != nr) begin
      dec_t = aes_pcbc_pkg::mix_inv(dec_t);
    end
    if (cmd.blk_start) begin
      rk_nxt = (dir_r == aes_pcbc_pkg::DIR_DECRYPT) ? AW'(nr) : '0;
    end else if (cmd.blk_init || cmd.blk_round) begin
      rk_nxt = (dir_r == aes_pcbc_pkg::DIR_DECRYPT) ? rk_r - 1'b1 : rk_r + 1'b1;
    end
    if (cmd.blk_init) begin
      st_nxt = ((dir_r == aes_pcbc_pkg::DIR_DECRYPT) ? blk_r : blk_r ^ chain_r) ^ st_key;
    end else if (cmd.blk_round) begin
      st_nxt = (dir_r == aes_pcbc_pkg::DIR_DECRYPT) ? dec_t : enc_t;
    end
  end

  assign stat.round_last = (rcnt_r == nr);

  always_ff @(posedge clk) begin
    rk_r <= rk_nxt;
    st_r <= st_nxt;
    if (cmd.blk_init) begin
      rcnt_r <= 4'd1;
    end else if (cmd.blk_round) begin
      rcnt_r <= rcnt_r + 4'd1;
    end
    if (cmd.take) begin
      blk_r <= in_data;
    end
  end

  // config, chain and result
  always_comb begin
    chain_nxt = chain_r;
    res_nxt   = res_r;
    if (cmd.out_load) begin
      res_nxt   = (dir_r == aes_pcbc_pkg::DIR_DECRYPT) ? st_r ^ chain_r : st_r;
      chain_nxt = blk_r ^ res_nxt;
    end
    if (cfg_we) begin
      case (cfg_idx)
        aes_pcbc_pkg::REG_IV_HIGH: chain_nxt = {cfg_data, ivl_r};
        aes_pcbc_pkg::REG_IV_LOW:  chain_nxt = {ivh_r, cfg_data};
        default:                   chain_nxt = chain_nxt;
      endcase
    end
    out_valid_nxt = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < 4; j++) key_r[j] <= '0;
      klen_r      <= aes_pcbc_pkg::KL_128;
      dir_r       <= 1'b0;
      ivh_r       <= '0;
      ivl_r       <= '0;
      chain_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      chain_r     <= chain_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          aes_pcbc_pkg::REG_KEY_WORD_0: key_r[0] <= cfg_data;
          aes_pcbc_pkg::REG_KEY_WORD_1: key_r[1] <= cfg_data;
          aes_pcbc_pkg::REG_KEY_WORD_2: key_r[2] <= cfg_data;
          aes_pcbc_pkg::REG_KEY_WORD_3: key_r[3] <= cfg_data;
          aes_pcbc_pkg::REG_KEY_LENGTH: klen_r   <= cfg_data[1:0];
          aes_pcbc_pkg::REG_DIRECTION:  dir_r    <= cfg_data[0];
          aes_pcbc_pkg::REG_IV_HIGH:    ivh_r    <= cfg_data;
          aes_pcbc_pkg::REG_IV_LOW:     ivl_r    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign stat.key_wr  = cfg_we && (cfg_idx == aes_pcbc_pkg::REG_KEY_WORD_0 ||
                                   cfg_idx == aes_pcbc_pkg::REG_KEY_WORD_1 ||
                                   cfg_idx == aes_pcbc_pkg::REG_KEY_WORD_2 ||
                                   cfg_idx == aes_pcbc_pkg::REG_KEY_WORD_3 ||
                                   cfg_idx == aes_pcbc_pkg::REG_KEY_LENGTH);
  assign stat.out_busy = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = res_r;

endmodule

// ===== hdl/aes_pcbc_block_cipher.sv =====
// AES block cipher (128/192/256-bit key) in PCBC chaining mode.
// in_ch takes one 16-byte block per request; out_ch returns one result block
// per request, in order. cfg_ch writes the key words, key length, direction
// and IV; writes are taken every cycle and must only happen while idle.
// Writing an IV register reloads the chain from both IV registers.
// After a key or key length write, the next block first expands the key
// schedule, one 32-bit word per cycle, into a round key RAM of 128-bit rows.
// A block then passes through start and init states, then takes one
// cipher round per cycle through a shared round unit and the registered
// round key RAM read. One block is in flight at a time, since
// the chain of each block depends on the previous result.
// A new request is accepted while the previous result still waits on
// out_ch; if the receiver stalls, the finished block holds until taken.
// Reset clears the configuration registers to zero, loads the chain with
// zero and marks the key schedule as not expanded; no clearing pass is needed.
module aes_pcbc_block_cipher #(
  parameter int EXPANDED_KEY_BYTES = 240
) (
  input logic            clk,
  input logic            rst_n,
  aes_pcbc_in_if.sink    in_ch,
  aes_pcbc_out_if.source out_ch,
  aes_pcbc_cfg_if.sink   cfg_ch
);

  aes_pcbc_pkg::ctrl_cmd_t cmd;
  aes_pcbc_pkg::dp_stat_t  stat;
  logic                    in_ready;
  logic [127:0]            out_data;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.result_high = out_data[127:64];
  assign out_ch.result_low  = out_data[63:0];

  aes_pcbc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  aes_pcbc_dp #(
    .EXPANDED_KEY_BYTES(EXPANDED_KEY_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  ({in_ch.block_high, in_ch.block_low}),
    .cfg_we   (cfg_ch.valid),
    .cfg_idx  (cfg_ch.index),
    .cfg_data (cfg_ch.data),
    .out_ready(out_ch.ready),
    .out_valid(out_ch.valid),
    .out_data (out_data)
  );

endmodule
